@@ rtl/dd_odo_pkg.sv @@
// Shared constants, codes and the quarter-wave sine table of the odometry step.
package dd_odo_pkg;

  // Operation codes carried in s_tuser
  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  // Field widths
  localparam int COUNT_W = 32;
  localparam int HEAD_W  = 16;
  localparam int SCALE_W = 24;
  localparam int MM_W    = 32;
  localparam int TDATA_W = 2 * COUNT_W + HEAD_W;

  // (dl + dr) * scale, and its clamp to +-(2^55 - 1)
  localparam int PROD_W = COUNT_W + 1 + SCALE_W;
  localparam int PSAT_W = 56;
  localparam logic signed [PROD_W-1:0] PROD_MAX = (PROD_W'(1) <<< (PSAT_W - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] PROD_MIN = -PROD_MAX;

  // Heading reduction: offset keeps the value positive with the same residue mod 360
  localparam int               HRED_W      = 17;
  localparam logic [HRED_W-1:0] HEAD_OFFSET = HRED_W'(36000);
  localparam int               RED_STEPS   = 8;
  localparam logic [HRED_W-1:0] RED_DIV0    = HRED_W'(360) << (RED_STEPS - 1);

  localparam int             DEG_W   = 9;
  localparam logic [DEG_W-1:0] DEG_90  = DEG_W'(90);
  localparam logic [DEG_W-1:0] DEG_180 = DEG_W'(180);
  localparam logic [DEG_W-1:0] DEG_270 = DEG_W'(270);
  localparam logic [DEG_W-1:0] DEG_360 = DEG_W'(360);

  localparam int IDX_W = 7;
  localparam int SIN_W = 16;

  // round(32768 * sin(k deg)), k = 0..90
  localparam logic [SIN_W-1:0] SIN_Q15 [91] = '{
    16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
    16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
    16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
    16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
    16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
    16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
    16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
    16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
    16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
    16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
    16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
    16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
  };

  function automatic logic [SIN_W-1:0] sin_q15(input logic [IDX_W-1:0] idx);
    logic [SIN_W-1:0] v;
    v = '0;
    if (idx <= IDX_W'(90)) begin
      v = SIN_Q15[idx];
    end
    return v;
  endfunction

endpackage

@@ rtl/diff_drive_odometry_step.sv @@
// Differential-drive dead-reckoning odometry: one pose update per encoder/gyro sample.
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+-------------------------------------------
//  cfg     | in  | cfg_valid / cfg_ready      | cfg_data: mm_per_tick_q16 (Q8.16, unsigned)
//  s       | in  | s_tvalid / s_tready        | s_tdata: left, right count, heading; s_tuser: func
//  m       | out | m_tvalid / m_tready        | m_tdata: pos_x_mm, pos_y_mm, heading_out
//
//  Update sample: one shared shift-add multiplier, retiring one multiplier bit per cycle,
//  runs three passes: distance, distance*sin, distance*cos. A clear skips the passes.
//  Input is accepted only in the idle state, so one sample is processed at a time.
//  Reset (rst, synchronous) zeroes the pose, previous counts, heading and scale.
//  A finished result sits in the m register; the next sample is taken while it waits,
//  and only the final load stalls on m_tready.
module diff_drive_odometry_step #(
  parameter int POS_FRAC_BITS  = 16,
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data,   // mm_per_tick_q16
  // sample in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,    // [31:0] left_count, [63:32] right_count, [79:64] heading_deg
  input  logic [0:0]  s_tuser,    // [0] func
  // pose out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata     // [31:0] pos_x_mm, [63:32] pos_y_mm, [79:64] heading_out
);

  // Pose accumulator, Q32.POS_FRAC_BITS
  localparam int AW    = 32 + POS_FRAC_BITS;
  // Distance alignment from the doubled Q16 product
  localparam int DSH_L = (POS_FRAC_BITS >= 17) ? (POS_FRAC_BITS - 17) : 0;
  localparam int DSH_R = (POS_FRAC_BITS < 17) ? (17 - POS_FRAC_BITS) : 0;
  localparam int DWIDE = dd_odo_pkg::PSAT_W + DSH_L;
  localparam int DW    = DWIDE - DSH_R;
  // Multiplier: signed multiplicand MW, unsigned multiplier NW bits
  localparam int TW    = TRIG_FRAC_BITS + 1;
  localparam int MW    = DW + 1;
  localparam int NW    = (TW > dd_odo_pkg::SCALE_W) ? TW : dd_odo_pkg::SCALE_W;
  localparam int HW    = MW + 1;
  localparam int RW    = HW + NW;
  localparam int CW    = $clog2(NW);
  // Increment and saturating add
  localparam int IW    = DW + 1;
  localparam int SW    = DW + 2;
  // Trig table rescale
  localparam int TSH_L = (TRIG_FRAC_BITS >= 15) ? (TRIG_FRAC_BITS - 15) : 0;
  localparam int TSH_R = (TRIG_FRAC_BITS < 15) ? (15 - TRIG_FRAC_BITS) : 0;
  localparam int EW    = dd_odo_pkg::SIN_W + TSH_L + 1;
  localparam int RND   = (1 << TSH_R) >> 1;

  localparam logic signed [SW-1:0] ACC_MAX = {{(SW - AW + 1){1'b0}}, {(AW - 1){1'b1}}};
  localparam logic signed [SW-1:0] ACC_MIN = {{(SW - AW + 1){1'b1}}, {(AW - 1){1'b0}}};

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_SUM  = 10'b0000000010,
    ST_MULD = 10'b0000000100,
    ST_DIST = 10'b0000001000,
    ST_LDS  = 10'b0000010000,
    ST_MULS = 10'b0000100000,
    ST_ACCX = 10'b0001000000,
    ST_MULC = 10'b0010000000,
    ST_ACCY = 10'b0100000000,
    ST_FIN  = 10'b1000000000
  } odo_state_t;

  odo_state_t state, state_next;

  // Architectural state
  logic [dd_odo_pkg::SCALE_W-1:0] scale;
  logic [dd_odo_pkg::COUNT_W-1:0] prev_left, prev_right;
  logic signed [AW-1:0]           acc_x, acc_y;
  logic [dd_odo_pkg::HEAD_W-1:0]  held_heading;

  // Working registers
  logic signed [dd_odo_pkg::COUNT_W-1:0] dl, dr;
  logic signed [MW-1:0]                  mreg;
  logic [RW-1:0]                         pp;
  logic [CW-1:0]                         cnt;
  logic [dd_odo_pkg::HRED_W-1:0]         red, red_div;
  logic signed [DW-1:0]                  travel;
  logic [TW-1:0]                         s_mag, c_mag;
  logic                                  s_neg, c_neg;

  // Datapath
  logic signed [dd_odo_pkg::COUNT_W:0]  sum;
  logic signed [HW-1:0]                 hi_cur, addend_m, hi_sum;
  logic [RW-1:0]                        pp_step;
  logic                                 mul_last;
  logic signed [dd_odo_pkg::PROD_W-1:0] prod_raw;
  logic signed [dd_odo_pkg::PSAT_W-1:0] prod_sat;
  logic signed [DWIDE-1:0]              dwide;
  logic signed [DW-1:0]                 travel_next;
  logic [dd_odo_pkg::DEG_W-1:0]         deg, s_idx9, c_idx9;
  logic                                 s_neg_next, c_neg_next;
  logic signed [RW-1:0]                 pp_shr;
  logic signed [IW-1:0]                 inc;
  logic signed [SW-1:0]                 acc_add, acc_sum;
  logic signed [AW-1:0]                 acc_sel, acc_new;
  logic [dd_odo_pkg::MM_W-1:0]          x_mm, y_mm;
  logic                                 out_free;

  function automatic logic [TW-1:0] trig_scale(input logic [dd_odo_pkg::SIN_W-1:0] e);
    logic [EW-1:0] w;
    w = ((EW'(e) << TSH_L) + EW'(RND)) >> TSH_R;
    return TW'(w);
  endfunction

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  // Shift-add step: add multiplicand on the current multiplier bit, shift one right
  always_comb begin
    sum      = (dd_odo_pkg::COUNT_W + 1)'(dl) + (dd_odo_pkg::COUNT_W + 1)'(dr);
    hi_cur   = $signed(pp[RW-1:NW]);
    addend_m = pp[0] ? HW'(mreg) : HW'(0);
    hi_sum   = hi_cur + addend_m;
    pp_step  = {hi_sum[HW-1], hi_sum, pp[NW-1:1]};
    mul_last = (cnt == CW'(NW - 1));
  end

  // Distance: clamp the doubled product, then align to the pose fraction (floor)
  always_comb begin
    prod_raw = $signed(pp[dd_odo_pkg::PROD_W-1:0]);
    if (prod_raw > dd_odo_pkg::PROD_MAX) begin
      prod_sat = dd_odo_pkg::PSAT_W'(dd_odo_pkg::PROD_MAX);
    end else if (prod_raw < dd_odo_pkg::PROD_MIN) begin
      prod_sat = dd_odo_pkg::PSAT_W'(dd_odo_pkg::PROD_MIN);
    end else begin
      prod_sat = dd_odo_pkg::PSAT_W'(prod_raw);
    end
    dwide       = DWIDE'(prod_sat) <<< DSH_L;
    travel_next = DW'(dwide >>> DSH_R);
  end

  // Quadrant folding of the reduced heading
  always_comb begin
    deg = red[dd_odo_pkg::DEG_W-1:0];
    if (deg < dd_odo_pkg::DEG_90) begin
      s_idx9 = deg;                       c_idx9 = dd_odo_pkg::DEG_90 - deg;
      s_neg_next = 1'b0;                  c_neg_next = 1'b0;
    end else if (deg < dd_odo_pkg::DEG_180) begin
      s_idx9 = dd_odo_pkg::DEG_180 - deg; c_idx9 = deg - dd_odo_pkg::DEG_90;
      s_neg_next = 1'b0;                  c_neg_next = 1'b1;
    end else if (deg < dd_odo_pkg::DEG_270) begin
      s_idx9 = deg - dd_odo_pkg::DEG_180; c_idx9 = dd_odo_pkg::DEG_270 - deg;
      s_neg_next = 1'b1;                  c_neg_next = 1'b1;
    end else begin
      s_idx9 = dd_odo_pkg::DEG_360 - deg; c_idx9 = deg - dd_odo_pkg::DEG_270;
      s_neg_next = 1'b1;                  c_neg_next = 1'b0;
    end
  end

  // Pose step: floor(travel*trig / 2^TRIG_FRAC_BITS), x subtracts, y adds, then saturate
  always_comb begin
    pp_shr  = $signed(pp) >>> TRIG_FRAC_BITS;
    inc     = pp_shr[IW-1:0];
    acc_add = (state == ST_ACCX) ? -SW'(inc) : SW'(inc);
    acc_sel = (state == ST_ACCX) ? acc_x : acc_y;
    acc_sum = SW'(acc_sel) + acc_add;
    if (acc_sum > ACC_MAX) begin
      acc_new = AW'(ACC_MAX);
    end else if (acc_sum < ACC_MIN) begin
      acc_new = AW'(ACC_MIN);
    end else begin
      acc_new = AW'(acc_sum);
    end
  end

  // Whole mm, truncated toward zero
  always_comb begin
    x_mm = acc_x[AW-1:POS_FRAC_BITS]
         + dd_odo_pkg::MM_W'(acc_x[AW-1] && (|acc_x[POS_FRAC_BITS-1:0]));
    y_mm = acc_y[AW-1:POS_FRAC_BITS]
         + dd_odo_pkg::MM_W'(acc_y[AW-1] && (|acc_y[POS_FRAC_BITS-1:0]));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tuser[0] == dd_odo_pkg::FUNC_CLEAR) ? ST_FIN : ST_SUM;
        end
      end
      ST_SUM:  state_next = ST_MULD;
      ST_MULD: if (mul_last) state_next = ST_DIST;
      ST_DIST: state_next = ST_LDS;
      ST_LDS:  state_next = ST_MULS;
      ST_MULS: if (mul_last) state_next = ST_ACCX;
      ST_ACCX: state_next = ST_MULC;
      ST_MULC: if (mul_last) state_next = ST_ACCY;
      ST_ACCY: state_next = ST_FIN;
      ST_FIN:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      m_tvalid     <= 1'b0;
      scale        <= '0;
      prev_left    <= '0;
      prev_right   <= '0;
      acc_x        <= '0;
      acc_y        <= '0;
      held_heading <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        scale <= cfg_data;
      end
      if (state == ST_IDLE && s_tvalid) begin
        if (s_tuser[0] == dd_odo_pkg::FUNC_CLEAR) begin
          acc_x        <= '0;
          acc_y        <= '0;
          held_heading <= '0;
        end else begin
          prev_left    <= s_tdata[31:0];
          prev_right   <= s_tdata[63:32];
          held_heading <= s_tdata[79:64];
        end
      end
      if (state == ST_ACCX) acc_x <= acc_new;
      if (state == ST_ACCY) acc_y <= acc_new;
      if (state == ST_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        dl      <= $signed(s_tdata[31:0] - prev_left);
        dr      <= $signed(s_tdata[63:32] - prev_right);
        red     <= dd_odo_pkg::HRED_W'($signed(s_tdata[79:64])) + dd_odo_pkg::HEAD_OFFSET;
        red_div <= dd_odo_pkg::RED_DIV0;
      end
      ST_SUM: begin
        mreg <= MW'(sum);
        pp   <= {HW'(0), NW'(scale)};
        cnt  <= '0;
      end
      ST_MULD, ST_MULS, ST_MULC: begin
        pp  <= pp_step;
        cnt <= cnt + CW'(1);
        // heading mod 360, one quotient bit per cycle during the first pass
        if (state == ST_MULD && cnt < CW'(dd_odo_pkg::RED_STEPS)) begin
          if (red >= red_div) red <= red - red_div;
          red_div <= red_div >> 1;
        end
      end
      ST_DIST: begin
        travel <= travel_next;
        s_mag  <= trig_scale(dd_odo_pkg::sin_q15(s_idx9[dd_odo_pkg::IDX_W-1:0]));
        c_mag  <= trig_scale(dd_odo_pkg::sin_q15(c_idx9[dd_odo_pkg::IDX_W-1:0]));
        s_neg  <= s_neg_next;
        c_neg  <= c_neg_next;
      end
      ST_LDS: begin
        mreg <= s_neg ? -MW'(travel) : MW'(travel);
        pp   <= {HW'(0), NW'(s_mag)};
        cnt  <= '0;
      end
      ST_ACCX: begin
        mreg <= c_neg ? -MW'(travel) : MW'(travel);
        pp   <= {HW'(0), NW'(c_mag)};
        cnt  <= '0;
      end
      ST_ACCY: begin
        cnt <= '0;
      end
      ST_FIN: begin
        if (out_free) begin
          m_tdata <= {held_heading, y_mm, x_mm};
        end
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

endmodule

@@ rtl/dd_odo_chk.sv @@
// Port-level checker for the odometry step, bound to the top level.
module dd_odo_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [dd_odo_pkg::TDATA_W-1:0] m_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or dropped while stalled");

  // one sample at a time
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a transfer");

  // clear with an empty output register passes through ST_FIN and then shows the origin
  a_clear_origin: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == dd_odo_pkg::FUNC_CLEAR) && !m_tvalid
    |=> ##1 (m_tvalid && (m_tdata == '0)))
    else $error("clear did not yield a zero pose");

  // a new result only appears at the end of processing, never from idle
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared while idle");

endmodule

bind diff_drive_odometry_step dd_odo_chk u_dd_odo_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
